[rtl/cau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DW        = 16;              // width of one operand part
    localparam int STEPS     = DW;              // quotient and root bits
    localparam int PW        = 2 * DW;          // product width
    localparam int NW        = PW + 1 + FRAC_BITS; // scaled divide numerator
    localparam int DIRW      = PW + 2 - FRAC_BITS; // unclamped result width
    localparam int RW        = PW + 2;          // divide remainder width
    localparam int SRW       = DW + 4;          // square root remainder width
    localparam int HALF_LSB  = 1 << (FRAC_BITS - 1);

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_MAG  = 3'd4;
    localparam logic [2:0] CMD_CONJ = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [2:0]           cmd;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } cau_req_t;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic [1:0]           status;
    } cau_rsp_t;

    // Item state carried through the divide / square root steps
    typedef struct packed {
        logic [2:0]             cmd;
        logic signed [DIRW-1:0] dir_re;
        logic signed [DIRW-1:0] dir_im;
        logic                   div0;
        logic                   neg_re;
        logic                   neg_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic [DW-1:0]          n_re;
        logic [DW-1:0]          n_im;
        logic [PW:0]            d2;
        logic [RW-1:0]          r_re;
        logic [RW-1:0]          r_im;
        logic [DW-1:0]          q_re;
        logic [DW-1:0]          q_im;
        logic [PW-1:0]          sq;
        logic [SRW-1:0]         srem;
        logic [DW:0]            sroot;
    } cau_work_t;

endpackage
`default_nettype wire

[rtl/cau_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Three pipeline stages: products and add/sub/conj results, sums of products,
// then multiply rounding and setup of the divide and square root steps.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire cau_req_t  in_data,
    output logic           up_en,
    input  wire logic      dn_en,
    output logic           out_valid,
    output cau_work_t      out_work
);

    logic en1, en2, en3;
    logic s1_v_reg, s2_v_reg, s3_v_reg;

    // stage 1
    logic [2:0]           s1_cmd_reg, s1_cmd_next;
    logic signed [PW-1:0] s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic signed [PW-1:0] s1_rr_next, s1_ii_next, s1_ri_next, s1_ir_next;
    logic signed [PW-1:0] s1_sqr_reg, s1_sqi_reg, s1_sqr_next, s1_sqi_next;
    logic signed [DW:0]   s1_dre_reg, s1_dim_reg, s1_dre_next, s1_dim_next;
    logic signed [DW-1:0] x_re, x_im;

    // stage 2
    logic [2:0]           s2_cmd_reg;
    logic signed [PW:0]   s2_num_re_reg, s2_num_im_reg, s2_num_re_next, s2_num_im_next;
    logic [PW-1:0]        s2_sum_reg, s2_sum_next;
    logic signed [DW:0]   s2_dre_reg, s2_dim_reg;

    // stage 3
    cau_work_t            s3_reg, s3_next;
    logic [PW:0]          abs_re, abs_im, rnd_re, rnd_im;
    logic signed [DIRW-1:0] mq_re, mq_im;
    logic [NW-1:0]        nn_re, nn_im;
    logic [RW-1:0]        d2_ext;

    assign en3   = !s3_v_reg || dn_en;
    assign en2   = !s2_v_reg || en3;
    assign en1   = !s1_v_reg || en2;
    assign up_en = en1;

    always_comb
    begin
        s1_cmd_next = in_data.cmd;
        x_re        = (in_data.cmd == CMD_MAG) ? in_data.a_re : in_data.b_re;
        x_im        = (in_data.cmd == CMD_MAG) ? in_data.a_im : in_data.b_im;
        s1_rr_next  = PW'(in_data.a_re) * PW'(in_data.b_re);
        s1_ii_next  = PW'(in_data.a_im) * PW'(in_data.b_im);
        s1_ri_next  = PW'(in_data.a_re) * PW'(in_data.b_im);
        s1_ir_next  = PW'(in_data.a_im) * PW'(in_data.b_re);
        s1_sqr_next = PW'(x_re) * PW'(x_re);
        s1_sqi_next = PW'(x_im) * PW'(x_im);
        case (in_data.cmd)
            CMD_ADD:
            begin
                s1_dre_next = (DW+1)'(in_data.a_re) + (DW+1)'(in_data.b_re);
                s1_dim_next = (DW+1)'(in_data.a_im) + (DW+1)'(in_data.b_im);
            end
            CMD_SUB:
            begin
                s1_dre_next = (DW+1)'(in_data.a_re) - (DW+1)'(in_data.b_re);
                s1_dim_next = (DW+1)'(in_data.a_im) - (DW+1)'(in_data.b_im);
            end
            CMD_CONJ:
            begin
                s1_dre_next = (DW+1)'(in_data.a_re);
                s1_dim_next = -(DW+1)'(in_data.a_im);
            end
            default:
            begin
                s1_dre_next = '0;
                s1_dim_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (s1_cmd_reg == CMD_MUL)
        begin
            s2_num_re_next = (PW+1)'(s1_rr_reg) - (PW+1)'(s1_ii_reg);
            s2_num_im_next = (PW+1)'(s1_ri_reg) + (PW+1)'(s1_ir_reg);
        end
        else
        begin
            s2_num_re_next = (PW+1)'(s1_rr_reg) + (PW+1)'(s1_ii_reg);
            s2_num_im_next = (PW+1)'(s1_ir_reg) - (PW+1)'(s1_ri_reg);
        end
        s2_sum_next = $unsigned(s1_sqr_reg) + $unsigned(s1_sqi_reg);
    end

    always_comb
    begin
        abs_re = s2_num_re_reg[PW] ? $unsigned(-s2_num_re_reg) : $unsigned(s2_num_re_reg);
        abs_im = s2_num_im_reg[PW] ? $unsigned(-s2_num_im_reg) : $unsigned(s2_num_im_reg);
        rnd_re = (abs_re + (PW+1)'(HALF_LSB)) >> FRAC_BITS;
        rnd_im = (abs_im + (PW+1)'(HALF_LSB)) >> FRAC_BITS;
        mq_re  = DIRW'(rnd_re);
        mq_im  = DIRW'(rnd_im);
        // numerator scaled by 2^(F+1), plus den for round to nearest
        nn_re  = (NW'(abs_re[PW-1:0]) << (FRAC_BITS + 1)) + NW'(s2_sum_reg);
        nn_im  = (NW'(abs_im[PW-1:0]) << (FRAC_BITS + 1)) + NW'(s2_sum_reg);
        d2_ext = RW'({s2_sum_reg, 1'b0});

        s3_next.cmd    = s2_cmd_reg;
        if (s2_cmd_reg == CMD_MUL)
        begin
            s3_next.dir_re = s2_num_re_reg[PW] ? -mq_re : mq_re;
            s3_next.dir_im = s2_num_im_reg[PW] ? -mq_im : mq_im;
        end
        else
        begin
            s3_next.dir_re = DIRW'(s2_dre_reg);
            s3_next.dir_im = DIRW'(s2_dim_reg);
        end
        s3_next.div0   = (s2_sum_reg == '0);
        s3_next.neg_re = s2_num_re_reg[PW];
        s3_next.neg_im = s2_num_im_reg[PW];
        s3_next.ovf_re = RW'(nn_re[NW-1:DW]) >= d2_ext;
        s3_next.ovf_im = RW'(nn_im[NW-1:DW]) >= d2_ext;
        s3_next.n_re   = nn_re[DW-1:0];
        s3_next.n_im   = nn_im[DW-1:0];
        s3_next.d2     = {s2_sum_reg, 1'b0};
        s3_next.r_re   = RW'(nn_re[NW-1:DW]);
        s3_next.r_im   = RW'(nn_im[NW-1:DW]);
        s3_next.q_re   = '0;
        s3_next.q_im   = '0;
        s3_next.sq     = s2_sum_reg;
        s3_next.srem   = '0;
        s3_next.sroot  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= in_valid;
            if (en2)
                s2_v_reg <= s1_v_reg;
            if (en3)
                s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cmd_reg <= s1_cmd_next;
            s1_rr_reg  <= s1_rr_next;
            s1_ii_reg  <= s1_ii_next;
            s1_ri_reg  <= s1_ri_next;
            s1_ir_reg  <= s1_ir_next;
            s1_sqr_reg <= s1_sqr_next;
            s1_sqi_reg <= s1_sqi_next;
            s1_dre_reg <= s1_dre_next;
            s1_dim_reg <= s1_dim_next;
        end
        if (en2)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_num_re_reg <= s2_num_re_next;
            s2_num_im_reg <= s2_num_im_next;
            s2_sum_reg    <= s2_sum_next;
            s2_dre_reg    <= s1_dre_reg;
            s2_dim_reg    <= s1_dim_reg;
        end
        if (en3)
            s3_reg <= s3_next;
    end

    assign out_valid = s3_v_reg;
    assign out_work  = s3_reg;

endmodule
`default_nettype wire

[rtl/cau_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_step
// One pipeline stage of the restoring divide (both parts) and the
// digit-by-digit square root: one quotient bit and one root bit per stage.
// ----------------------------------------------------------------------------
module cau_step import cau_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire cau_work_t in_work,
    output logic           up_en,
    input  wire logic      dn_en,
    output logic           out_valid,
    output cau_work_t      out_work
);

    logic           v_reg;
    logic           en;
    cau_work_t      work_reg, work_next;
    logic [RW-1:0]  rs_re, rs_im, d2_ext;
    logic [SRW-1:0] rem_sh, trial;

    assign en    = !v_reg || dn_en;
    assign up_en = en;

    always_comb
    begin
        work_next = in_work;
        d2_ext    = RW'(in_work.d2);

        rs_re = {in_work.r_re[RW-2:0], in_work.n_re[DW-1]};
        rs_im = {in_work.r_im[RW-2:0], in_work.n_im[DW-1]};
        work_next.n_re = {in_work.n_re[DW-2:0], 1'b0};
        work_next.n_im = {in_work.n_im[DW-2:0], 1'b0};
        if (rs_re >= d2_ext)
        begin
            work_next.r_re = rs_re - d2_ext;
            work_next.q_re = {in_work.q_re[DW-2:0], 1'b1};
        end
        else
        begin
            work_next.r_re = rs_re;
            work_next.q_re = {in_work.q_re[DW-2:0], 1'b0};
        end
        if (rs_im >= d2_ext)
        begin
            work_next.r_im = rs_im - d2_ext;
            work_next.q_im = {in_work.q_im[DW-2:0], 1'b1};
        end
        else
        begin
            work_next.r_im = rs_im;
            work_next.q_im = {in_work.q_im[DW-2:0], 1'b0};
        end

        // bring down the next two radicand bits
        rem_sh = {in_work.srem[SRW-3:0], in_work.sq[PW-1:PW-2]};
        trial  = SRW'({in_work.sroot, 2'b01});
        work_next.sq = {in_work.sq[PW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            work_next.srem  = rem_sh - trial;
            work_next.sroot = {in_work.sroot[DW-1:0], 1'b1};
        end
        else
        begin
            work_next.srem  = rem_sh;
            work_next.sroot = {in_work.sroot[DW-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_reg <= work_next;
    end

    assign out_valid = v_reg;
    assign out_work  = work_reg;

endmodule
`default_nettype wire

[rtl/cau_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Result select, sign, saturation and status; output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire cau_work_t in_work,
    output logic           up_en,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output cau_rsp_t       rsp
);

    logic                   v_reg;
    logic                   en;
    cau_rsp_t               rsp_reg, rsp_next;
    logic [DIRW-1:0]        dmag_re, dmag_im;
    logic signed [DIRW-1:0] val_re, val_im;
    logic [DW:0]            cl_re, cl_im;

    // returns {saturated, clamped value}
    function automatic logic [DW:0] clamp_dw(input logic signed [DIRW-1:0] x);
        logic ovf;
        ovf = (x[DIRW-1:DW-1] != {(DIRW-DW+1){x[DIRW-1]}});
        if (ovf)
            return {1'b1, x[DIRW-1], {(DW-1){~x[DIRW-1]}}};
        return {1'b0, x[DW-1:0]};
    endfunction

    assign en    = !v_reg || !rsp_stall;
    assign up_en = en;

    always_comb
    begin
        dmag_re = in_work.ovf_re ? DIRW'({1'b1, {DW{1'b0}}}) : DIRW'(in_work.q_re);
        dmag_im = in_work.ovf_im ? DIRW'({1'b1, {DW{1'b0}}}) : DIRW'(in_work.q_im);
        case (in_work.cmd)
            CMD_DIV:
            begin
                val_re = in_work.neg_re ? -$signed(dmag_re) : $signed(dmag_re);
                val_im = in_work.neg_im ? -$signed(dmag_im) : $signed(dmag_im);
            end
            CMD_MAG:
            begin
                // round up when the remainder exceeds the root
                val_re = $signed(DIRW'(in_work.sroot)
                         + DIRW'(in_work.srem > SRW'(in_work.sroot)));
                val_im = '0;
            end
            default:
            begin
                val_re = in_work.dir_re;
                val_im = in_work.dir_im;
            end
        endcase
        cl_re = clamp_dw(val_re);
        cl_im = clamp_dw(val_im);

        if (in_work.cmd == CMD_DIV && in_work.div0)
        begin
            rsp_next.res_re = '0;
            rsp_next.res_im = '0;
            rsp_next.status = ST_DIV0;
        end
        else
        begin
            rsp_next.res_re = cl_re[DW-1:0];
            rsp_next.res_im = cl_im[DW-1:0];
            rsp_next.status = (cl_re[DW] || cl_im[DW]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = v_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, sub, mul, div, magnitude, conjugate in Q8.8.
// ----------------------------------------------------------------------------
// Every command passes 3 front stages, 16 divide / square root stages at one
// bit each and 1 output register on its way from accept to rsp_valid.
// Throughput: one item per cycle; each stage holds only while the next is full
// and stalled, so bubbles are filled.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire cau_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output cau_rsp_t      rsp
);

    logic        front_up_en;
    logic [STEPS:0] stp_v;
    logic [STEPS:0] stp_en;
    cau_work_t   stp_w [STEPS+1];

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_data   (req),
        .up_en     (front_up_en),
        .dn_en     (stp_en[0]),
        .out_valid (stp_v[0]),
        .out_work  (stp_w[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cau_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stp_v[i]),
            .in_work   (stp_w[i]),
            .up_en     (stp_en[i]),
            .dn_en     (stp_en[i+1]),
            .out_valid (stp_v[i+1]),
            .out_work  (stp_w[i+1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stp_v[STEPS]),
        .in_work   (stp_w[STEPS]),
        .up_en     (stp_en[STEPS]),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign req_stall = !front_up_en;

    // an empty output register lets every stage advance
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled while output register empty");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIV0 |-> rsp.res_re == '0 && rsp.res_im == '0)
        else $error("divide by zero with nonzero result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_DIV0
                      || rsp.status == ST_SAT)
        else $error("undefined status code");

endmodule
`default_nettype wire
